// File: src/pti_pkg.sv
// ----------------------------------------------------------------------------
// pti_pkg
// Shared widths, register indexes, item types and saturation helper for the
// piecewise threshold interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

	localparam int VW = 16;            // value width of every lane
	localparam int LANE_W = 16;        // lane pitch inside a register
	localparam int OUT_W = 16;         // port width of the signed values
	localparam int REG_W = 4 * LANE_W; // config register width
	localparam int NUM_REGS = 6;
	localparam int IDX_W = $clog2(NUM_REGS);
	localparam int DW = VW + 1;        // differences of two values
	localparam int PW = 2 * DW;        // signed product
	localparam int MW = PW - 1;        // product magnitude, quotient width
	localparam int SW = MW + 2;        // midpoint sum before saturation
	localparam int QD = 4;             // queue depth between front and back
	localparam int QAW = $clog2(QD);

	localparam logic [IDX_W-1:0] REG_BOUNDS = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_BELOW = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_SEG1 = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SEG2 = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_SEG3 = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_ABOVE = IDX_W'(5);

	// classified item handed from front to back
	typedef struct packed {
		logic pass;                  // cuts given directly in a and b
		logic div_en;                // midpoint needs the interpolation
		logic status;
		logic signed [VW-1:0] a;     // locut, or low threshold
		logic signed [VW-1:0] m;     // midpoint when not interpolated
		logic signed [VW-1:0] b;     // hicut, or confidence range
		logic signed [VW-1:0] power;
		logic signed [DW-1:0] num;
		logic signed [DW-1:0] dthr;
		logic signed [DW-1:0] span;
	} item_t;

	typedef struct packed {
		logic signed [VW-1:0] zero_cut;
		logic signed [VW-1:0] full_cut;
		logic signed [VW-1:0] mid;
		logic signed [VW-1:0] power;
		logic status;
	} result_t;

	function automatic logic signed [VW-1:0] sat_vw(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] maxv;
		logic signed [SW-1:0] minv;
		maxv = SW'((VW+1)'({1'b0, {(VW-1){1'b1}}}));
		minv = -maxv - SW'(1);
		if (v > maxv) begin
			return maxv[VW-1:0];
		end else if (v < minv) begin
			return minv[VW-1:0];
		end
		return v[VW-1:0];
	endfunction

endpackage

// File: src/pti_front.sv
// ----------------------------------------------------------------------------
// pti_front
// Holds the config registers, picks the region and segment of each
// temperature and forms the operands of the interpolation.
// ----------------------------------------------------------------------------
module pti_front import pti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	input  logic signed [OUT_W-1:0] brightness_temp,
	output item_t item
);

	logic [REG_W-1:0] regs_q [NUM_REGS];
	logic signed [VW-1:0] bt, b0, b1, b2, b3, lo, hi;
	logic [REG_W-1:0] set;
	logic found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOUNDS: regs_q[0] <= cfg_data;
				REG_BELOW:  regs_q[1] <= cfg_data;
				REG_SEG1:   regs_q[2] <= cfg_data;
				REG_SEG2:   regs_q[3] <= cfg_data;
				REG_SEG3:   regs_q[4] <= cfg_data;
				REG_ABOVE:  regs_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic signed [VW-1:0] lane(input logic [REG_W-1:0] r, input int k);
		return r[LANE_W*k +: VW];
	endfunction

	always_comb begin
		bt = brightness_temp[VW-1:0];
		b0 = lane(regs_q[0], 0);
		b1 = lane(regs_q[0], 1);
		b2 = lane(regs_q[0], 2);
		b3 = lane(regs_q[0], 3);
		item = '0;
		set = '0;
		lo = b0;
		hi = b3;
		found = 1'b1;
		if (bt < b0 || bt > b3) begin
			set = (bt < b0) ? regs_q[1] : regs_q[5];
			item.pass = 1'b1;
			item.a = lane(set, 0);
			item.m = lane(set, 1);
			item.b = lane(set, 2);
			item.power = lane(set, 3);
		end else begin
			if (b1 == '0 && b2 == '0) begin
				set = regs_q[2];
			end else if (bt < b1) begin
				set = regs_q[2];
				hi = b1;
			end else if (bt < b2) begin
				set = regs_q[3];
				lo = b1;
				hi = b2;
			end else if (bt >= b2) begin
				set = regs_q[4];
				lo = b2;
			end else begin
				found = 1'b0;
			end
			if (!found) begin
				// bounds out of order: everything zero but the status flag
				item.pass = 1'b1;
				item.status = 1'b1;
			end else begin
				item.a = lane(set, 0);
				item.m = lane(set, 0);
				item.b = lane(set, 2);
				item.power = lane(set, 3);
				item.num = DW'(bt) - DW'(lo);
				item.dthr = DW'(lane(set, 1)) - DW'(lane(set, 0));
				item.span = DW'(hi) - DW'(lo);
				item.div_en = (hi != lo);
				item.status = (hi == lo);
			end
		end
	end

endmodule

// File: src/pti_queue.sv
// ----------------------------------------------------------------------------
// pti_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module pti_queue import pti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  item_t wr_item,
	output logic full,
	input  logic rd,
	output logic empty,
	output item_t rd_item
);

	item_t mem_q [QD];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0] cnt_q;

	assign full = (cnt_q == (QAW+1)'(QD));
	assign empty = (cnt_q == '0);
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 1'b1;
			if (rd && !empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(wr && !full) - (QAW+1)'(rd && !empty);
		end
	end

endmodule

// File: src/pti_back.sv
// ----------------------------------------------------------------------------
// pti_back
// Multiply, restoring divide one quotient bit per stage, midpoint and cut
// saturation, and a two-entry result queue.
// ----------------------------------------------------------------------------
module pti_back import pti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  item_t q_item,
	output logic q_pop,
	output logic empty,
	input  logic pop,
	output result_t result
);

	logic adv;
	logic v_s1, v_s2, v_fa, v_fb;
	item_t pl_s1, pl_fa;
	logic signed [PW-1:0] p_s1;
	logic [DW-1:0] dmag_s1;
	logic dneg_s1;

	logic v_d [MW+1];
	item_t pl_d [MW+1];
	logic [DW-1:0] rem_d [MW+1];
	logic [MW-1:0] dvd_d [MW+1];
	logic [MW-1:0] quo_d [MW+1];
	logic [DW-1:0] dmag_d [MW+1];
	logic sign_d [MW+1];

	logic signed [VW-1:0] mid_fa;
	result_t res_fb;
	logic signed [SW-1:0] qx, sum;

	result_t oq_q [2];
	logic owp_q, orp_q;
	logic [1:0] ocnt_q;
	logic ofull;

	assign ofull = (ocnt_q == 2'd2);
	assign adv = !(v_fb && ofull);
	assign q_pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_d[0] <= 1'b0;
			v_fa <= 1'b0;
			v_fb <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_d[0] <= v_s1;
			v_fa <= v_d[MW];
			v_fb <= v_fa;
		end
	end

	// multiply and divisor magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s1 <= q_item;
			p_s1 <= PW'(q_item.num) * PW'(q_item.dthr);
			dneg_s1 <= q_item.span[DW-1];
			dmag_s1 <= q_item.span[DW-1] ? DW'(-q_item.span) : DW'(q_item.span);
		end
	end

	// dividend magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			pl_d[0] <= pl_s1;
			dvd_d[0] <= p_s1[PW-1] ? MW'(-p_s1) : MW'(p_s1);
			sign_d[0] <= p_s1[PW-1] ^ dneg_s1;
			dmag_d[0] <= dmag_s1;
			rem_d[0] <= '0;
			quo_d[0] <= '0;
		end
	end

	for (genvar j = 0; j < MW; j++) begin : g_div
		logic [DW:0] trial;
		logic ge;
		assign trial = {rem_d[j], dvd_d[j][MW-1]};
		assign ge = (trial >= {1'b0, dmag_d[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[j+1] <= 1'b0;
			end else if (adv) begin
				v_d[j+1] <= v_d[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_d[j+1] <= ge ? DW'(trial - {1'b0, dmag_d[j]}) : trial[DW-1:0];
				dvd_d[j+1] <= dvd_d[j] << 1;
				quo_d[j+1] <= {quo_d[j][MW-2:0], ge};
				dmag_d[j+1] <= dmag_d[j];
				sign_d[j+1] <= sign_d[j];
				pl_d[j+1] <= pl_d[j];
			end
		end
	end

	// quotient truncated toward zero, added to the low threshold
	always_comb begin
		qx = SW'({1'b0, quo_d[MW]});
		sum = sign_d[MW] ? (SW'(pl_d[MW].a) - qx) : (SW'(pl_d[MW].a) + qx);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_fa <= pl_d[MW];
			mid_fa <= pl_d[MW].div_en ? sat_vw(sum) : pl_d[MW].m;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_fb.mid <= mid_fa;
			res_fb.power <= pl_fa.power;
			res_fb.status <= pl_fa.status;
			if (pl_fa.pass) begin
				res_fb.zero_cut <= pl_fa.a;
				res_fb.full_cut <= pl_fa.b;
			end else begin
				res_fb.zero_cut <= sat_vw(SW'(mid_fa) + SW'(pl_fa.b));
				res_fb.full_cut <= sat_vw(SW'(mid_fa) - SW'(pl_fa.b));
			end
		end
	end

	// result queue
	assign empty = (ocnt_q == 2'd0);
	assign result = oq_q[orp_q];

	always_ff @(posedge clk) begin
		if (v_fb && !ofull) oq_q[owp_q] <= res_fb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= 1'b0;
			orp_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (v_fb && !ofull) owp_q <= !owp_q;
			if (pop && !empty) orp_q <= !orp_q;
			ocnt_q <= ocnt_q + 2'(v_fb && !ofull) - 2'(pop && !empty);
		end
	end

endmodule

// File: src/piecewise_threshold_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_threshold_interpolator
// Per-pixel cut values from one brightness temperature and six config
// registers of packed signed fixed-point lanes.
// ----------------------------------------------------------------------------
// One temperature in, one result out, one item per cycle sustained while the
// output queue is popped and does not fill. The front classifies the item in the
// cycle it is pushed and writes it into a four-deep queue; the back then runs it
// through its pipeline (multiply, magnitude, a 33-stage restoring divider giving
// one quotient bit per stage, midpoint and cut saturation) before the result shows
// in a two-entry output queue. The user must write config registers with cfg_we
// only while the block holds no items; the block itself does not enforce this.
module piecewise_threshold_interpolator import pti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	input  logic push,
	output logic full,
	input  logic signed [OUT_W-1:0] brightness_temp,
	output logic empty,
	input  logic pop,
	output logic signed [OUT_W-1:0] zero_conf_cut,
	output logic signed [OUT_W-1:0] full_conf_cut,
	output logic signed [OUT_W-1:0] mid_point,
	output logic signed [OUT_W-1:0] curve_power,
	output logic status
);

	item_t f_item, q_item;
	logic q_empty, q_pop;
	result_t result;

	pti_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.brightness_temp(brightness_temp),
		.item(f_item)
	);

	pti_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(push),
		.wr_item(f_item),
		.full(full),
		.rd(q_pop),
		.empty(q_empty),
		.rd_item(q_item)
	);

	pti_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_item(q_item),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	assign zero_conf_cut = OUT_W'(result.zero_cut);
	assign full_conf_cut = OUT_W'(result.full_cut);
	assign mid_point = OUT_W'(result.mid);
	assign curve_power = OUT_W'(result.power);
	assign status = result.status;

endmodule

// File: tb/sv/pti_checker.sv
// ----------------------------------------------------------------------------
// pti_checker
// Watches the config port and both queue sides of the interpolator. It keeps
// its own copy of the registers, predicts the cuts of every temperature beat
// and compares each popped result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module pti_checker import pti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	input  logic push,
	input  logic full,
	input  logic signed [OUT_W-1:0] brightness_temp,
	input  logic empty,
	input  logic pop,
	input  logic signed [OUT_W-1:0] zero_conf_cut,
	input  logic signed [OUT_W-1:0] full_conf_cut,
	input  logic signed [OUT_W-1:0] mid_point,
	input  logic signed [OUT_W-1:0] curve_power,
	input  logic status,
	output int errors,
	output int outstanding
);

	logic [REG_W-1:0] cfg_copy [NUM_REGS];
	result_t cuts_due [$];
	int n_popped;

	function automatic longint lane_of(input logic [REG_W-1:0] r, input int k);
		logic signed [LANE_W-1:0] v;
		v = r[LANE_W*k +: LANE_W];
		return longint'(v);
	endfunction

	function automatic longint clamp_vw(input longint v);
		if (v > 32767) begin
			return 32767;
		end else if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	function automatic result_t predict_cuts(input logic signed [OUT_W-1:0] temp);
		longint bt, b0, b1, b2, b3, lo, hi, tlo, thi, rng, q;
		longint zc, fc, md, pw;
		logic [REG_W-1:0] sel;
		logic found, st;
		result_t r;
		bt = longint'(temp);
		b0 = lane_of(cfg_copy[REG_BOUNDS], 0);
		b1 = lane_of(cfg_copy[REG_BOUNDS], 1);
		b2 = lane_of(cfg_copy[REG_BOUNDS], 2);
		b3 = lane_of(cfg_copy[REG_BOUNDS], 3);
		zc = 0; fc = 0; md = 0; pw = 0; st = 1'b0;
		found = 1'b1; lo = 0; hi = 0; sel = '0;
		if (bt < b0 || bt > b3) begin
			sel = (bt < b0) ? cfg_copy[REG_BELOW] : cfg_copy[REG_ABOVE];
			zc = lane_of(sel, 0);
			md = lane_of(sel, 1);
			fc = lane_of(sel, 2);
			pw = lane_of(sel, 3);
		end else begin
			if (b1 == 0 && b2 == 0) begin
				sel = cfg_copy[REG_SEG1]; lo = b0; hi = b3;
			end else if (bt < b1) begin
				sel = cfg_copy[REG_SEG1]; lo = b0; hi = b1;
			end else if (bt < b2) begin
				sel = cfg_copy[REG_SEG2]; lo = b1; hi = b2;
			end else if (bt >= b2 && bt <= b3) begin
				sel = cfg_copy[REG_SEG3]; lo = b2; hi = b3;
			end else begin
				found = 1'b0;
			end
			if (!found) begin
				st = 1'b1;
			end else begin
				tlo = lane_of(sel, 0);
				thi = lane_of(sel, 1);
				rng = lane_of(sel, 2);
				pw = lane_of(sel, 3);
				if (hi == lo) begin
					st = 1'b1;
					md = tlo;
				end else begin
					// signed longint division truncates toward zero
					q = ((bt - lo) * (thi - tlo)) / (hi - lo);
					md = clamp_vw(tlo + q);
				end
				zc = clamp_vw(md + rng);
				fc = clamp_vw(md - rng);
			end
		end
		r.zero_cut = VW'(clamp_vw(zc));
		r.full_cut = VW'(clamp_vw(fc));
		r.mid = VW'(clamp_vw(md));
		r.power = VW'(clamp_vw(pw));
		r.status = st;
		return r;
	endfunction

	task automatic report(input string field, input longint got, input longint want);
		$display("mismatch on result %0d: %s got %0d, want %0d", n_popped, field, got, want);
		errors++;
	endtask

	assign outstanding = cuts_due.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_copy[i] <= '0;
			end
			cuts_due.delete();
			errors <= 0;
			n_popped <= 0;
		end else begin
			if (cfg_we && cfg_index < NUM_REGS) begin
				cfg_copy[cfg_index] <= cfg_data;
			end
			if (push && !full) begin
				cuts_due.push_back(predict_cuts(brightness_temp));
			end
			if (pop && !empty) begin
				n_popped <= n_popped + 1;
				if (cuts_due.size() == 0) begin
					$display("result beat %0d popped with nothing expected", n_popped);
					errors++;
				end else begin
					want = cuts_due.pop_front();
					if (zero_conf_cut !== want.zero_cut)
						report("zero_conf_cut", zero_conf_cut, want.zero_cut);
					if (full_conf_cut !== want.full_cut)
						report("full_conf_cut", full_conf_cut, want.full_cut);
					if (mid_point !== want.mid)
						report("mid_point", mid_point, want.mid);
					if (curve_power !== want.power)
						report("curve_power", curve_power, want.power);
					if (status !== want.status)
						report("status", status, want.status);
				end
			end
		end
	end

endmodule

// File: tb/sv/tb_piecewise_threshold_interpolator.sv
// ----------------------------------------------------------------------------
// tb_piecewise_threshold_interpolator
// Drives temperatures and config phases into the interpolator with random
// gaps on both queue sides, one long pop hold-off and pauses until drained;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_piecewise_threshold_interpolator;
	import pti_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic push;
	logic full;
	logic signed [OUT_W-1:0] brightness_temp;
	logic empty;
	logic pop;
	logic signed [OUT_W-1:0] zero_conf_cut;
	logic signed [OUT_W-1:0] full_conf_cut;
	logic signed [OUT_W-1:0] mid_point;
	logic signed [OUT_W-1:0] curve_power;
	logic status;
	int errors;
	int outstanding;
	logic send_burst;
	logic [15:0] bnd [4];

	piecewise_threshold_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .brightness_temp(brightness_temp),
		.empty(empty), .pop(pop),
		.zero_conf_cut(zero_conf_cut), .full_conf_cut(full_conf_cut),
		.mid_point(mid_point), .curve_power(curve_power), .status(status)
	);

	pti_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .brightness_temp(brightness_temp),
		.empty(empty), .pop(pop),
		.zero_conf_cut(zero_conf_cut), .full_conf_cut(full_conf_cut),
		.mid_point(mid_point), .curve_power(curve_power), .status(status),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("[piecewise_threshold_interpolator] ERROR");
		$finish;
	end

	function automatic logic [REG_W-1:0] pack4(input logic [15:0] l0, input logic [15:0] l1,
			input logic [15:0] l2, input logic [15:0] l3);
		return {l3, l2, l1, l0};
	endfunction

	function automatic logic [REG_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// cfg_we drops after each write, which keeps writes apart in time
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every result, then let the pipeline settle before a register write
	task automatic drain();
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_temp(input logic [15:0] v);
		int gap;
		logic f;
		gap = send_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		brightness_temp <= v;
		do begin
			@(negedge clk);
			f = full;
			@(posedge clk);
		end while (f);
	endtask

	task automatic end_beats();
		push <= 1'b0;
	endtask

	// bounds laid out from bnd[]
	task automatic write_bounds();
		write_reg(REG_BOUNDS, pack4(bnd[0], bnd[1], bnd[2], bnd[3]));
	endtask

	task automatic random_config();
		int kind, mag;
		logic [15:0] t;
		kind = $urandom_range(0, 9);
		mag = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(20, 600);
		for (int i = 0; i < 4; i++) begin
			bnd[i] = 16'($signed($urandom_range(0, 2 * mag)) - mag);
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3 - i; j++) begin
				if ($signed(bnd[j]) > $signed(bnd[j+1])) begin
					t = bnd[j]; bnd[j] = bnd[j+1]; bnd[j+1] = t;
				end
			end
		end
		if (kind == 0) begin
			// whole segment
			bnd[1] = '0; bnd[2] = '0;
			if ($signed(bnd[0]) > 0) bnd[0] = -bnd[0];
			if ($signed(bnd[3]) < 0) bnd[3] = -bnd[3];
		end else if (kind == 1) begin
			bnd[1] = bnd[0];
		end else if (kind == 2) begin
			bnd[3] = bnd[2];
		end else if (kind == 3) begin
			for (int i = 0; i < 4; i++) bnd[i] = 16'($urandom());
		end
		write_bounds();
		write_reg(REG_BELOW, rand64());
		write_reg(REG_SEG1, rand64());
		write_reg(REG_SEG2, rand64());
		write_reg(REG_SEG3, rand64());
		write_reg(REG_ABOVE, rand64());
	endtask

	task automatic random_temps(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
			k = $urandom_range(0, 9);
			if (k < 6) begin
				send_temp(bnd[$urandom_range(0, 3)] + 16'($signed($urandom_range(0, 40)) - 20));
			end else begin
				send_temp(16'($urandom()));
			end
		end
		end_beats();
	endtask

	// receiver: random pop gaps, one long hold-off while the sender keeps going
	initial begin
		int gap, n_rx;
		logic e;
		logic burst;
		pop = 1'b0;
		n_rx = 0;
		burst = 1'b0;
		@(posedge arst_n);
		forever begin
			if (n_rx % 50 == 0) burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 19);
			if (n_rx == 150) gap = 1500;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(negedge clk);
				e = empty;
				@(posedge clk);
			end while (e);
			n_rx++;
		end
	end

	initial begin
		int lim;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		brightness_temp = '0;
		send_burst = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: all bounds zero, only zero passes the middle
		send_temp(16'sd0);
		send_temp(16'sd1);
		send_temp(-16'sd1);
		end_beats();
		drain();

		// saturating thresholds on ascending bounds
		bnd[0] = -16'sd1000; bnd[1] = -16'sd200; bnd[2] = 16'sd300; bnd[3] = 16'sd1500;
		write_bounds();
		write_reg(REG_BELOW, pack4(16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
		write_reg(REG_SEG1, pack4(16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
		write_reg(REG_SEG2, pack4(16'h7fff, 16'h8000, 16'h8000, 16'h0001));
		write_reg(REG_SEG3, pack4(16'd100, -16'sd50, 16'd0, 16'hffff));
		write_reg(REG_ABOVE, pack4(16'h7fff, 16'h0000, 16'hffff, 16'h8000));
		send_temp(16'h8000);
		send_temp(16'h7fff);
		send_temp(-16'sd1001);
		send_temp(-16'sd1000);
		send_temp(-16'sd201);
		send_temp(-16'sd200);
		send_temp(16'sd0);
		send_temp(16'sd300);
		send_temp(16'sd1500);
		send_temp(16'sd1501);
		end_beats();
		drain();

		// whole segment and zero span
		bnd[0] = -16'sd64; bnd[1] = '0; bnd[2] = '0; bnd[3] = 16'sd64;
		write_bounds();
		send_temp(-16'sd64);
		send_temp(16'sd17);
		send_temp(16'sd64);
		bnd[0] = 16'sd5; bnd[1] = 16'sd5; bnd[2] = 16'sd9; bnd[3] = 16'sd9;
		end_beats();
		drain();
		write_bounds();
		send_temp(16'sd5);
		send_temp(16'sd7);
		send_temp(16'sd9);
		end_beats();
		drain();

		// extreme bounds at the negative and positive ends, every other register all ones
		bnd[0] = 16'h8000; bnd[1] = 16'h8000; bnd[2] = 16'h7fff; bnd[3] = 16'h7fff;
		write_bounds();
		for (int r = 1; r < NUM_REGS; r++) write_reg(IDX_W'(r), {REG_W{1'b1}});
		send_temp(16'h8000);
		send_temp(16'h0000);
		send_temp(16'h7fff);
		end_beats();
		drain();

		for (int p = 0; p < 8; p++) begin
			random_config();
			random_temps(125);
			drain();
		end

		lim = 0;
		while (outstanding != 0 && lim < 200000) begin
			@(posedge clk);
			lim++;
		end
		repeat (60) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("[piecewise_threshold_interpolator] OK");
		end else begin
			$display("[piecewise_threshold_interpolator] ERROR");
		end
		$finish;
	end

endmodule
